// File: rtl/trail_ribbon_extruder_assert.svh
// Assertion macros used by the trail ribbon extruder controller.
`ifndef TRAIL_RIBBON_EXTRUDER_ASSERT_SVH
`define TRAIL_RIBBON_EXTRUDER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TRE_ASSERT_SAME(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("trail ribbon extruder check failed");

// The consequent must hold in the cycle after the antecedent.
`define TRE_ASSERT_NEXT(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("trail ribbon extruder check failed");

`endif

// File: rtl/tre_pkg.sv
// Types, constants and helper functions of the trail ribbon extruder.
package tre_pkg;

   localparam int MAX_POINTS = 1024;
   localparam logic [10:0] MIN_POINTS = 11'd5;
   localparam logic [10:0] SEG_MAX = 11'd2047;
   localparam logic [15:0] MAX_WIDTH_RESET = 16'd256;
   localparam logic [14:0] BLUE_BASE = 15'd24576;
   localparam logic CSR_IDX_MAX_WIDTH = 1'b0;

   localparam int PDIV_STEPS = 14;
   localparam int SQRT_STEPS = 32;
   localparam int QDIV_STEPS = 25;
   localparam logic [4:0] PDIV_LAST = 5'(PDIV_STEPS - 1);
   localparam logic [4:0] SQRT_LAST = 5'(SQRT_STEPS - 1);
   localparam logic [4:0] QDIV_LAST = 5'(QDIV_STEPS - 1);

   typedef struct packed {
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_z;
      logic [15:0] age_fraction;
      logic [10:0] point_count;
      logic first_point;
   } req_payload_type;

   typedef struct packed {
      logic signed [31:0] vert_x;
      logic signed [31:0] vert_y;
      logic signed [31:0] vert_z;
      logic [14:0] red;
      logic [13:0] green;
      logic [14:0] blue;
      logic [14:0] alpha;
      logic side;
      logic last;
   } rsp_payload_type;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_PDIV,
      OP_MUL_WA,
      OP_MUL_WP,
      OP_MUL_XX,
      OP_MUL_ZZ,
      OP_SQRT_INIT,
      OP_SQRT,
      OP_MUL_NX,
      OP_MUL_NZ,
      OP_QDIV_INIT,
      OP_QDIV,
      OP_FINISH
   } dp_op_type;

   typedef struct packed {
      logic capture;
      dp_op_type op;
      logic side;
   } dp_cmd_type;

   typedef struct packed {
      logic emit;
   } dp_status_type;

   // Clamps a 34-bit signed sum to the signed 32-bit range.
   function automatic logic [31:0] sat32(input logic signed [33:0] v);
      logic [31:0] r;
      if ((v[33] == v[32]) && (v[32] == v[31])) begin
         r = v[31:0];
      end else if (v[33]) begin
         r = 32'h8000_0000;
      end else begin
         r = 32'h7FFF_FFFF;
      end
      return r;
   endfunction

endpackage

// File: rtl/tre_if.sv
// Handshake channels for trail points and ribbon vertices.
interface tre_req_if import tre_pkg::*; ();
   logic valid;
   logic ready;
   req_payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface tre_rsp_if import tre_pkg::*; ();
   logic valid;
   logic ready;
   rsp_payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// File: rtl/trail_ribbon_extruder.sv
// Top level of the trail ribbon extruder: channels, register port, controller and datapath.
//
//  channel   | direction | word                                   | handshake
//  req_chan  | in        | one trail point with trail data        | valid/ready
//  rsp_chan  | out       | one ribbon vertex with colour          | valid/ready
//  csr_*     | in        | max_width register, byte address 0     | APB write/read
//
// A point that closes a segment passes through the colour-ramp divider, the shared multiplier,
// the square root, the two offset dividers side by side, and setup and the final sums before
// its first vertex word is valid. The two vertex words follow. Other points start no segment,
// and the input stays open for the next point.
// Reset is synchronous and clears the trail state; the input opens in the cycle after reset.
// A stalled result holds its word; no new point is taken until the second word leaves.
module trail_ribbon_extruder import tre_pkg::*; (
   input logic clock,
   input logic reset,
   tre_req_if.sink req_chan,
   tre_rsp_if.source rsp_chan,
   input logic csr_psel,
   input logic csr_penable,
   input logic csr_pwrite,
   input logic [2:0] csr_paddr,
   input logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic csr_pready
);

   logic [15:0] max_width_ff;
   logic csr_write;
   dp_cmd_type cmd;
   dp_status_type status;

   assign csr_pready = 1'b1;
   assign csr_write = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_width_ff <= MAX_WIDTH_RESET;
      end else if (csr_write && (csr_paddr[2] == CSR_IDX_MAX_WIDTH)) begin
         max_width_ff <= csr_pwdata[15:0];
      end
   end

   assign csr_prdata = (csr_paddr[2] == CSR_IDX_MAX_WIDTH) ? {16'd0, max_width_ff} : 32'd0;

   tre_ctrl u_ctrl (
      .clock(clock),
      .reset(reset),
      .req_valid(req_chan.valid),
      .rsp_ready(rsp_chan.ready),
      .status(status),
      .req_ready(req_chan.ready),
      .rsp_valid(rsp_chan.valid),
      .cmd(cmd)
   );

   tre_datapath u_datapath (
      .clock(clock),
      .reset(reset),
      .cmd(cmd),
      .req(req_chan.payload),
      .max_width(max_width_ff),
      .rsp(rsp_chan.payload),
      .status(status)
   );

endmodule

// File: rtl/tre_datapath.sv
// Datapath: trail state, shared multiplier, dividers, square root, vertex registers.
module tre_datapath import tre_pkg::*; (
   input logic clock,
   input logic reset,
   input dp_cmd_type cmd,
   input req_payload_type req,
   input logic [15:0] max_width,
   output rsp_payload_type rsp,
   output dp_status_type status
);

   logic signed [31:0] prev_x_ff, prev_y_ff, prev_z_ff;
   logic [10:0] seg_ff, len_ff;
   logic [15:0] age_ff;

   logic signed [31:0] ax_ff, ay_ff, az_ff;
   logic signed [32:0] dx_ff, dz_ff;
   logic [30:0] mx_ff, mz_ff;
   logic neg_x_ff, pos_z_ff;
   logic [10:0] pd_rem_ff, pd_div_ff;
   logic [13:0] pq_ff;
   logic [63:0] prod_ff, sqx_ff;
   logic [24:0] w_ff;
   logic [63:0] rad_ff, res_ff, bit_ff;
   logic [31:0] len_l_ff;
   logic [55:0] numx_ff, numz_ff;
   logic [31:0] rx_ff, rz_ff;
   logic [24:0] qx_ff, qz_ff;
   logic [31:0] vx0_ff, vx1_ff, vz0_ff, vz1_ff;

   logic [31:0] mul_a, mul_b;
   logic [63:0] product;
   logic [32:0] mag_x, mag_z;
   logic [1:0] shift;
   logic [11:0] pd_t;
   logic [63:0] sq_trial;
   logic [32:0] tx, tz;
   logic signed [32:0] dx_in, dz_in;
   logic signed [33:0] off_x, off_z, ax_w, az_w;
   logic [24:0] ox, oz;
   logic len_ok;

   assign len_ok = (len_ff >= MIN_POINTS) && (32'(len_ff) <= MAX_POINTS);
   assign status.emit = !req.first_point && len_ok &&
                        (({1'b0, seg_ff} + 12'd1) < {1'b0, len_ff});

   assign dx_in = {req.pos_x[31], req.pos_x} - {prev_x_ff[31], prev_x_ff};
   assign dz_in = {req.pos_z[31], req.pos_z} - {prev_z_ff[31], prev_z_ff};

   always_comb begin
      mul_a = 32'd0;
      mul_b = 32'd0;
      case (cmd.op)
         OP_MUL_WA: begin
            mul_a = {16'd0, max_width};
            mul_b = {16'd0, age_ff};
         end
         OP_MUL_WP: begin
            mul_a = prod_ff[31:0];
            mul_b = {18'd0, pq_ff};
         end
         OP_MUL_XX: begin
            mul_a = {1'b0, mx_ff};
            mul_b = {1'b0, mx_ff};
         end
         OP_MUL_ZZ: begin
            mul_a = {1'b0, mz_ff};
            mul_b = {1'b0, mz_ff};
         end
         OP_MUL_NX: begin
            mul_a = {7'd0, w_ff};
            mul_b = {1'b0, mz_ff};
         end
         OP_MUL_NZ: begin
            mul_a = {7'd0, w_ff};
            mul_b = {1'b0, mx_ff};
         end
         default: begin
            mul_a = 32'd0;
            mul_b = 32'd0;
         end
      endcase
   end

   assign product = 64'(mul_a) * 64'(mul_b);

   assign mag_x = dx_ff[32] ? 33'(-dx_ff) : 33'(dx_ff);
   assign mag_z = dz_ff[32] ? 33'(-dz_ff) : 33'(dz_ff);
   assign shift = (mag_x[32] | mag_z[32]) ? 2'd2 : ((mag_x[31] | mag_z[31]) ? 2'd1 : 2'd0);

   assign pd_t = {pd_rem_ff, 1'b0};
   assign sq_trial = res_ff + bit_ff;
   assign tx = {rx_ff, numx_ff[24]};
   assign tz = {rz_ff, numz_ff[24]};

   // A zero-length horizontal direction leaves the offset at zero.
   assign ox = (len_l_ff == 32'd0) ? 25'd0 : qx_ff;
   assign oz = (len_l_ff == 32'd0) ? 25'd0 : qz_ff;
   assign off_x = pos_z_ff ? (34'sd0 - $signed({9'd0, ox})) : $signed({9'd0, ox});
   assign off_z = neg_x_ff ? (34'sd0 - $signed({9'd0, oz})) : $signed({9'd0, oz});
   assign ax_w = {ax_ff[31], ax_ff[31], ax_ff};
   assign az_w = {az_ff[31], az_ff[31], az_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_x_ff <= '0;
         prev_y_ff <= '0;
         prev_z_ff <= '0;
         seg_ff <= '0;
         len_ff <= '0;
         age_ff <= '0;
      end else if (cmd.capture) begin
         prev_x_ff <= req.pos_x;
         prev_y_ff <= req.pos_y;
         prev_z_ff <= req.pos_z;
         if (req.first_point) begin
            len_ff <= req.point_count;
            age_ff <= req.age_fraction;
            seg_ff <= '0;
         end else if (seg_ff != SEG_MAX) begin
            seg_ff <= seg_ff + 11'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         ax_ff <= prev_x_ff;
         ay_ff <= prev_y_ff;
         az_ff <= prev_z_ff;
         dx_ff <= dx_in;
         dz_ff <= dz_in;
         pd_rem_ff <= seg_ff;
         pd_div_ff <= len_ff - 11'd1;
         pq_ff <= '0;
      end
      case (cmd.op)
         OP_PDIV: begin
            if (pd_t >= {1'b0, pd_div_ff}) begin
               pd_rem_ff <= 11'(pd_t - {1'b0, pd_div_ff});
               pq_ff <= {pq_ff[12:0], 1'b1};
            end else begin
               pd_rem_ff <= pd_t[10:0];
               pq_ff <= {pq_ff[12:0], 1'b0};
            end
         end
         OP_MUL_WA: begin
            prod_ff <= product;
            mx_ff <= 31'(mag_x >> shift);
            mz_ff <= 31'(mag_z >> shift);
            neg_x_ff <= dx_ff[32];
            pos_z_ff <= !dz_ff[32] && (dz_ff != 33'sd0);
         end
         OP_MUL_WP: prod_ff <= product;
         OP_MUL_XX: begin
            w_ff <= prod_ff[45:21];
            prod_ff <= product;
         end
         OP_MUL_ZZ: begin
            sqx_ff <= prod_ff;
            prod_ff <= product;
         end
         OP_SQRT_INIT: begin
            rad_ff <= sqx_ff + prod_ff;
            res_ff <= '0;
            bit_ff <= 64'h4000_0000_0000_0000;
         end
         OP_SQRT: begin
            if (rad_ff >= sq_trial) begin
               rad_ff <= rad_ff - sq_trial;
               res_ff <= (res_ff >> 1) + bit_ff;
            end else begin
               res_ff <= res_ff >> 1;
            end
            bit_ff <= bit_ff >> 2;
         end
         OP_MUL_NX: begin
            len_l_ff <= res_ff[31:0];
            prod_ff <= product;
         end
         OP_MUL_NZ: begin
            numx_ff <= prod_ff[55:0];
            prod_ff <= product;
         end
         OP_QDIV_INIT: begin
            // The quotient stays below 2^25, so the upper bits start below the divisor.
            rx_ff <= {1'b0, numx_ff[55:25]};
            rz_ff <= {1'b0, prod_ff[55:25]};
            numz_ff <= prod_ff[55:0];
            qx_ff <= '0;
            qz_ff <= '0;
         end
         OP_QDIV: begin
            if (tx >= {1'b0, len_l_ff}) begin
               rx_ff <= 32'(tx - {1'b0, len_l_ff});
               qx_ff <= {qx_ff[23:0], 1'b1};
            end else begin
               rx_ff <= tx[31:0];
               qx_ff <= {qx_ff[23:0], 1'b0};
            end
            if (tz >= {1'b0, len_l_ff}) begin
               rz_ff <= 32'(tz - {1'b0, len_l_ff});
               qz_ff <= {qz_ff[23:0], 1'b1};
            end else begin
               rz_ff <= tz[31:0];
               qz_ff <= {qz_ff[23:0], 1'b0};
            end
            numx_ff <= numx_ff << 1;
            numz_ff <= numz_ff << 1;
         end
         OP_FINISH: begin
            vx0_ff <= sat32(ax_w - off_x);
            vx1_ff <= sat32(ax_w + off_x);
            vz0_ff <= sat32(az_w - off_z);
            vz1_ff <= sat32(az_w + off_z);
         end
         default: begin
         end
      endcase
   end

   assign rsp.vert_x = cmd.side ? vx1_ff : vx0_ff;
   assign rsp.vert_y = ay_ff;
   assign rsp.vert_z = cmd.side ? vz1_ff : vz0_ff;
   assign rsp.red = {1'b0, pq_ff};
   assign rsp.green = {1'b0, pq_ff[13:1]};
   assign rsp.blue = BLUE_BASE - {1'b0, pq_ff};
   assign rsp.alpha = {1'b0, pq_ff};
   assign rsp.side = cmd.side;
   assign rsp.last = cmd.side;

endmodule

// File: rtl/tre_ctrl.sv
// Controller: sequences the datapath steps and the two output words of a segment.
`include "trail_ribbon_extruder_assert.svh"
module tre_ctrl import tre_pkg::*; (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic rsp_ready,
   input dp_status_type status,
   output logic req_ready,
   output logic rsp_valid,
   output dp_cmd_type cmd
);

   typedef enum logic [3:0] {
      ST_IDLE, ST_PDIV, ST_MWA, ST_MWP, ST_MXX, ST_MZZ, ST_SINIT, ST_SQRT,
      ST_MNX, ST_MNZ, ST_QINIT, ST_QDIV, ST_FIN, ST_OUT0, ST_OUT1
   } state_type;

   state_type state_ff, state_in;
   logic [4:0] cnt_ff, cnt_in;
   logic req_ready_ff, req_ready_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic accept;

   assign accept = req_valid && req_ready_ff;
   assign req_ready = req_ready_ff;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd.capture = accept;
      cmd.side = (state_ff == ST_OUT1);
      case (state_ff)
         ST_PDIV: cmd.op = OP_PDIV;
         ST_MWA: cmd.op = OP_MUL_WA;
         ST_MWP: cmd.op = OP_MUL_WP;
         ST_MXX: cmd.op = OP_MUL_XX;
         ST_MZZ: cmd.op = OP_MUL_ZZ;
         ST_SINIT: cmd.op = OP_SQRT_INIT;
         ST_SQRT: cmd.op = OP_SQRT;
         ST_MNX: cmd.op = OP_MUL_NX;
         ST_MNZ: cmd.op = OP_MUL_NZ;
         ST_QINIT: cmd.op = OP_QDIV_INIT;
         ST_QDIV: cmd.op = OP_QDIV;
         ST_FIN: cmd.op = OP_FINISH;
         default: cmd.op = OP_NONE;
      endcase
   end

   always_comb begin
      state_in = state_ff;
      cnt_in = cnt_ff;
      req_ready_in = req_ready_ff;
      rsp_valid_in = rsp_valid_ff;
      case (state_ff)
         ST_IDLE: begin
            // The input opens in the cycle after reset and stays open between segments.
            req_ready_in = 1'b1;
            if (accept && status.emit) begin
               state_in = ST_PDIV;
               req_ready_in = 1'b0;
               cnt_in = '0;
            end
         end
         ST_PDIV: begin
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == PDIV_LAST) begin
               state_in = ST_MWA;
            end
         end
         ST_MWA: state_in = ST_MWP;
         ST_MWP: state_in = ST_MXX;
         ST_MXX: state_in = ST_MZZ;
         ST_MZZ: state_in = ST_SINIT;
         ST_SINIT: begin
            state_in = ST_SQRT;
            cnt_in = '0;
         end
         ST_SQRT: begin
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == SQRT_LAST) begin
               state_in = ST_MNX;
            end
         end
         ST_MNX: state_in = ST_MNZ;
         ST_MNZ: state_in = ST_QINIT;
         ST_QINIT: begin
            state_in = ST_QDIV;
            cnt_in = '0;
         end
         ST_QDIV: begin
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == QDIV_LAST) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            state_in = ST_OUT0;
            rsp_valid_in = 1'b1;
         end
         ST_OUT0: begin
            if (rsp_ready) begin
               state_in = ST_OUT1;
            end
         end
         ST_OUT1: begin
            if (rsp_ready) begin
               state_in = ST_IDLE;
               rsp_valid_in = 1'b0;
               req_ready_in = 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
            rsp_valid_in = 1'b0;
            req_ready_in = 1'b1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff <= '0;
         req_ready_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff <= cnt_in;
         req_ready_ff <= req_ready_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   `TRE_ASSERT_SAME(a_no_overlap, rsp_valid_ff, !req_ready_ff)
   `TRE_ASSERT_NEXT(a_pair_order, state_ff == ST_OUT0 && rsp_ready, state_ff == ST_OUT1 && rsp_valid_ff)
   `TRE_ASSERT_NEXT(a_skip_stays, accept && !status.emit, req_ready_ff && !rsp_valid_ff)
   `TRE_ASSERT_SAME(a_sqrt_bound, state_ff == ST_SQRT, cnt_ff <= SQRT_LAST)

endmodule
